/* hw/rtl/disk_sector_address_sequencer_assert.svh */
// Assertion macros used by the checker module of the sector sequencer.
`ifndef DISK_SECTOR_ADDRESS_SEQUENCER_ASSERT_SVH
`define DISK_SECTOR_ADDRESS_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DSAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sequencer assertion failed");

`endif

/* hw/rtl/dsas_pkg.sv */
package dsas_pkg;

	localparam int unsigned ADDR_W  = 28;
	localparam int unsigned CYL_W   = 16;
	localparam int unsigned HEAD_W  = 8;
	localparam int unsigned SECT_W  = 7;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned HC_W    = 5;
	localparam int unsigned SPT_W   = 6;
	localparam int unsigned TRACK_W = 22;
	localparam int unsigned CFG_W   = 6;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SECTOR = 1'b1;

	localparam logic REG_HEAD_COUNT        = 1'b0;
	localparam logic REG_SECTORS_PER_TRACK = 1'b1;

	localparam logic [HC_W-1:0]    HEAD_COUNT_RESET  = 5'd16;
	localparam logic [SPT_W-1:0]   SPT_RESET         = 6'd63;
	localparam logic [COUNT_W-1:0] FULL_COUNT        = 9'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL_SECTOR,
		ST_CHS_STEP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic start_load;
		logic idle_result;
		logic lba_step;
		logic mul_track;
		logic mul_sector;
		logic chs_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic active;
		logic linear;
		logic out_full;
	} status_t;

endpackage

/* hw/rtl/dsas_ctrl.sv */
module dsas_ctrl import dsas_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_stall,
	input  status_t status,
	output logic    in_stall,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.op == OP_START) begin
					cmd.start_load = 1'b1;
					state_next     = ST_FINISH;
				end else if (!status.active) begin
					cmd.idle_result = 1'b1;
					state_next      = ST_FINISH;
				end else if (status.linear) begin
					cmd.lba_step = 1'b1;
					state_next   = ST_FINISH;
				end else begin
					cmd.mul_track = 1'b1;
					state_next    = ST_MUL_SECTOR;
				end
			end
			ST_MUL_SECTOR: begin
				cmd.mul_sector = 1'b1;
				state_next     = ST_CHS_STEP;
			end
			ST_CHS_STEP: begin
				cmd.chs_step = 1'b1;
				state_next   = ST_FINISH;
			end
			ST_FINISH: begin
				if (!status.out_full || !out_stall) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/dsas_datapath.sv */
module dsas_datapath import dsas_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              op,
	input  logic              lba_mode,
	input  logic [ADDR_W-1:0] task_address,
	input  logic [7:0]        sector_count,
	input  logic              out_stall,
	output logic              out_valid,
	output logic              sector_valid,
	output logic [ADDR_W-1:0] media_address,
	output logic [ADDR_W-1:0] task_address_now,
	output logic              last_sector
);

	logic [HC_W-1:0]    hc_q;
	logic [SPT_W-1:0]   spt_q;
	logic [CYL_W-1:0]   cyl_q;
	logic [HEAD_W-1:0]  head_q;
	logic [SECT_W-1:0]  sect_q;
	logic [ADDR_W-1:0]  tfa_q;
	logic [COUNT_W-1:0] done_q;
	logic [COUNT_W-1:0] wanted_q;
	logic               lin_q;
	logic               out_valid_q;

	logic               op_q;
	logic               lba_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [7:0]         cnt_q;
	logic [TRACK_W-1:0] track_q;
	logic [ADDR_W-1:0]  prod_q;

	logic               res_valid_q;
	logic [ADDR_W-1:0]  res_media_q;
	logic [ADDR_W-1:0]  res_tan_q;
	logic               res_last_q;

	logic [ADDR_W-1:0]  out_media_q;
	logic [ADDR_W-1:0]  out_tan_q;
	logic               out_sv_q;
	logic               out_last_q;

	logic [20:0]        cyl_x_hc;
	logic [TRACK_W-1:0] track_sum;
	logic [ADDR_W-1:0]  track_x_spt;
	logic [ADDR_W-1:0]  media_chs;
	logic [ADDR_W-1:0]  tfa_chs;
	logic [SECT_W-1:0]  sect_inc;
	logic               sect_wrap;
	logic [HEAD_W-1:0]  head_inc;
	logic               head_wrap;
	logic [COUNT_W-1:0] done_inc;
	logic               last_hit;

	assign cyl_x_hc    = 21'(cyl_q) * 21'(hc_q);
	assign track_sum   = {1'b0, cyl_x_hc} + {14'd0, head_q};
	assign track_x_spt = 28'(track_q) * 28'(spt_q);
	assign media_chs   = prod_q + 28'(sect_q) - 28'd1;
	assign tfa_chs     = {head_q[3:0], cyl_q, tfa_q[7:6], sect_q[5:0]};
	assign sect_inc    = sect_q + 7'd1;
	assign sect_wrap   = sect_inc > {1'b0, spt_q};
	assign head_inc    = head_q + 8'd1;
	assign head_wrap   = head_inc == {3'd0, hc_q};
	assign done_inc    = done_q + 9'd1;
	assign last_hit    = done_inc == wanted_q;

	assign status.op       = op_q;
	assign status.active   = done_q < wanted_q;
	assign status.linear   = lin_q;
	assign status.out_full = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q  <= HEAD_COUNT_RESET;
			spt_q <= SPT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HEAD_COUNT:        hc_q  <= cfg_data[HC_W-1:0];
				REG_SECTORS_PER_TRACK: spt_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_q    <= '0;
			head_q   <= '0;
			sect_q   <= '0;
			tfa_q    <= '0;
			done_q   <= '0;
			wanted_q <= '0;
			lin_q    <= 1'b0;
		end else if (cmd.start_load) begin
			lin_q    <= lba_q;
			tfa_q    <= addr_q;
			wanted_q <= (cnt_q == 8'd0) ? FULL_COUNT : {1'b0, cnt_q};
			done_q   <= '0;
			cyl_q    <= addr_q[23:8];
			head_q   <= {4'd0, addr_q[27:24]};
			sect_q   <= {1'b0, addr_q[5:0]};
		end else if (cmd.lba_step) begin
			tfa_q  <= tfa_q + 28'd1;
			done_q <= done_inc;
		end else if (cmd.chs_step) begin
			tfa_q  <= tfa_chs;
			done_q <= done_inc;
			if (sect_wrap) begin
				sect_q <= 7'd1;
				if (head_wrap) begin
					head_q <= '0;
					cyl_q  <= cyl_q + 16'd1;
				end else begin
					head_q <= head_inc;
				end
			end else begin
				sect_q <= sect_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			lba_q  <= lba_mode;
			addr_q <= task_address;
			cnt_q  <= sector_count;
		end
		if (cmd.mul_track) begin
			track_q <= track_sum;
		end
		if (cmd.mul_sector) begin
			prod_q <= track_x_spt;
		end
		if (cmd.start_load) begin
			res_valid_q <= 1'b0;
			res_media_q <= '0;
			res_tan_q   <= addr_q;
			res_last_q  <= 1'b0;
		end else if (cmd.idle_result) begin
			res_valid_q <= 1'b0;
			res_media_q <= '0;
			res_tan_q   <= tfa_q;
			res_last_q  <= 1'b0;
		end else if (cmd.lba_step) begin
			res_valid_q <= 1'b1;
			res_media_q <= tfa_q;
			res_tan_q   <= tfa_q + 28'd1;
			res_last_q  <= last_hit;
		end else if (cmd.chs_step) begin
			res_valid_q <= 1'b1;
			res_media_q <= media_chs;
			res_tan_q   <= tfa_chs;
			res_last_q  <= last_hit;
		end
		if (cmd.out_load) begin
			out_sv_q    <= res_valid_q;
			out_media_q <= res_media_q;
			out_tan_q   <= res_tan_q;
			out_last_q  <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign sector_valid     = out_sv_q;
	assign media_address    = out_media_q;
	assign task_address_now = out_tan_q;
	assign last_sector      = out_last_q;

endmodule

/* hw/rtl/disk_sector_address_sequencer.sv */
// Sector address sequencer for multi-sector disk transfers.
// Input words arrive on in_valid/in_stall with fields op, lba_mode, task_address and
// sector_count. A start word (op = 0) loads the transfer; each sector word (op = 1)
// produces the media address of that sector and the updated task-file address.
// Every input word yields exactly one output word on out_valid/out_stall.
// The unit works on one word at a time. A start word, an ignored sector word and an
// LBA sector word pass through the decode and finish states to the output register; a
// CHS sector word also passes through the multiply and CHS step states, as the track
// and sector products go through two registered multiply steps. A new word is accepted
// only once the previous one has reached the output register.
// A result waiting in the output register does not block the next input word; the
// following result waits in the sequencer until the receiver drops out_stall.
// Reset clears the transfer state, empties the output register and sets head_count
// to 16 and sectors_per_track to 63. The configuration port writes one register per
// cycle with cfg_write and must only be used while the unit is idle.
module disk_sector_address_sequencer import dsas_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic              lba_mode,
	input  logic [ADDR_W-1:0] task_address,
	input  logic [7:0]        sector_count,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              sector_valid,
	output logic [ADDR_W-1:0] media_address,
	output logic [ADDR_W-1:0] task_address_now,
	output logic              last_sector
);

	cmd_t    cmd;
	status_t status;

	dsas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.status    (status),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	dsas_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.op               (op),
		.lba_mode         (lba_mode),
		.task_address     (task_address),
		.sector_count     (sector_count),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.sector_valid     (sector_valid),
		.media_address    (media_address),
		.task_address_now (task_address_now),
		.last_sector      (last_sector)
	);

endmodule

/* hw/rtl/dsas_checker.sv */
`include "disk_sector_address_sequencer_assert.svh"

module dsas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        sector_valid,
	input logic [27:0] media_address,
	input logic [27:0] task_address_now,
	input logic        last_sector
);

	`DSAS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(media_address) && $stable(task_address_now))
	`DSAS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`DSAS_ASSERT_SAME(a_no_sector_zero, clk, arst_n, out_valid && !sector_valid, media_address == 28'd0 && !last_sector)
	`DSAS_ASSERT_SAME(a_last_is_sector, clk, arst_n, out_valid && last_sector, sector_valid)

endmodule

bind disk_sector_address_sequencer dsas_checker u_dsas_checker (.*);

/* tb/disk_sector_address_sequencer_tb.sv */
module disk_sector_address_sequencer_tb;
	import dsas_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_TARGET = 1400;
	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE      = 8;

	typedef struct packed {
		logic              sector_valid;
		logic [ADDR_W-1:0] media_address;
		logic [ADDR_W-1:0] task_address_now;
		logic              last_sector;
	} sector_result_t;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic              op;
		logic              lba;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        count;
		logic [CFG_W-1:0]  heads;
		logic [CFG_W-1:0]  spt;
		logic              typed;
		sector_result_t    res;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_write;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic              op;
	logic              lba_mode;
	logic [ADDR_W-1:0] task_address;
	logic [7:0]        sector_count;
	logic              out_valid;
	logic              out_stall;
	logic              sector_valid;
	logic [ADDR_W-1:0] media_address;
	logic [ADDR_W-1:0] task_address_now;
	logic              last_sector;

	disk_sector_address_sequencer uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.lba_mode         (lba_mode),
		.task_address     (task_address),
		.sector_count     (sector_count),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sector_valid     (sector_valid),
		.media_address    (media_address),
		.task_address_now (task_address_now),
		.last_sector      (last_sector)
	);

	// Shadow copy of the sequencer state and geometry.
	logic [CYL_W-1:0]   cyl_q;
	logic [HEAD_W-1:0]  head_q;
	logic [SECT_W-1:0]  sect_q;
	logic [ADDR_W-1:0]  tfa_q;
	logic [COUNT_W-1:0] done_q;
	logic [COUNT_W-1:0] wanted_q;
	logic               linear_q;
	logic [HC_W-1:0]    geo_heads;
	logic [SPT_W-1:0]   geo_spt;

	sector_result_t awaited_results[$];

	logic           word_typed;
	sector_result_t word_typed_res;

	int errors;
	int starts_seen;
	int sectors_seen;
	int ignored_seen;
	int cfg_writes_seen;
	int words_sent;
	int idle_cycles;
	int rx_hold;
	bit tx_calm;
	bit rx_calm;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic advance_sequencer(input logic o, input logic l, input logic [ADDR_W-1:0] a,
			input logic [7:0] c, output sector_result_t r);
		logic [31:0] track;
		logic [31:0] media32;
		r = '0;
		if (o == OP_START) begin
			linear_q = l;
			tfa_q    = a;
			wanted_q = (c == 8'd0) ? FULL_COUNT : {1'b0, c};
			done_q   = '0;
			cyl_q    = a[23:8];
			head_q   = {4'b0, a[27:24]};
			sect_q   = {1'b0, a[5:0]};
		end else if (done_q < wanted_q) begin
			r.sector_valid = 1'b1;
			if (linear_q) begin
				r.media_address = tfa_q;
				tfa_q = tfa_q + 1'b1;
			end else begin
				track   = cyl_q * geo_heads + head_q;
				media32 = track * geo_spt + sect_q - 32'd1;
				r.media_address = media32[ADDR_W-1:0];
				tfa_q = (tfa_q & 28'h00000C0) | {22'b0, sect_q[5:0]} | {4'b0, cyl_q, 8'b0}
					| {head_q[3:0], 24'b0};
				sect_q = sect_q + 1'b1;
				if (sect_q > {1'b0, geo_spt}) begin
					sect_q = 7'd1;
					head_q = head_q + 1'b1;
					if (head_q == {3'b0, geo_heads}) begin
						head_q = '0;
						cyl_q  = cyl_q + 1'b1;
					end
				end
			end
			done_q = done_q + 1'b1;
			r.last_sector = (done_q == wanted_q);
		end
		r.task_address_now = tfa_q;
	endtask

	task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		sector_result_t r;
		sector_result_t w;
		if (!arst_n) begin
			cyl_q     <= '0;
			head_q    <= '0;
			sect_q    <= '0;
			tfa_q     <= '0;
			done_q    <= '0;
			wanted_q  <= '0;
			linear_q  <= 1'b0;
			geo_heads <= HEAD_COUNT_RESET;
			geo_spt   <= SPT_RESET;
		end else begin
			if (cfg_write) begin
				cfg_writes_seen++;
				if (cfg_index == REG_HEAD_COUNT)
					geo_heads = cfg_data[HC_W-1:0];
				else
					geo_spt = cfg_data[SPT_W-1:0];
			end
			if (in_valid && !in_stall) begin
				advance_sequencer(op, lba_mode, task_address, sector_count, r);
				if (op == OP_START)
					starts_seen++;
				else if (r.sector_valid)
					sectors_seen++;
				else
					ignored_seen++;
				awaited_results.push_back(word_typed ? word_typed_res : r);
			end
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with nothing awaited: valid %b media %h task %h last %b",
						$time, sector_valid, media_address, task_address_now, last_sector);
					errors++;
				end else begin
					w = awaited_results.pop_front();
					check_field("sector_valid", w.sector_valid, sector_valid);
					check_field("media_address", w.media_address, media_address);
					check_field("task_address_now", w.task_address_now, task_address_now);
					check_field("last_sector", w.last_sector, last_sector);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rx_hold = 0;
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				rx_hold = rx_calm ? 0 : $urandom_range(0, 8);
			else if (rx_hold > 0)
				rx_hold--;
			out_stall <= (rx_hold != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles, %0d results still awaited.",
				IDLE_LIMIT, awaited_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(input logic o, input logic l, input logic [ADDR_W-1:0] a,
			input logic [7:0] c, input logic typed, input sector_result_t res);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		op             <= o;
		lba_mode       <= l;
		task_address   <= a;
		sector_count   <= c;
		word_typed     <= typed;
		word_typed_res <= res;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic drain_sequencer();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [CFG_W-1:0] heads, input logic [CFG_W-1:0] spt);
		cfg_write <= 1'b1;
		cfg_index <= REG_HEAD_COUNT;
		cfg_data  <= heads;
		@(posedge clk);
		cfg_index <= REG_SECTORS_PER_TRACK;
		cfg_data  <= spt;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic stim_row_t word_row(input logic o, input logic l,
			input logic [ADDR_W-1:0] a, input logic [7:0] c);
		stim_row_t s;
		s       = '0;
		s.kind  = ROW_WORD;
		s.op    = o;
		s.lba   = l;
		s.addr  = a;
		s.count = c;
		return s;
	endfunction

	function automatic stim_row_t typed_row(input logic o, input logic l,
			input logic [ADDR_W-1:0] a, input logic [7:0] c, input logic sv,
			input logic [ADDR_W-1:0] m, input logic [ADDR_W-1:0] t, input logic last);
		stim_row_t s;
		s       = word_row(o, l, a, c);
		s.typed = 1'b1;
		s.res   = '{sv, m, t, last};
		return s;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] p);
		stim_row_t s;
		s       = '0;
		s.kind  = ROW_CFG;
		s.heads = h;
		s.spt   = p;
		return s;
	endfunction

	initial begin
		stim_row_t         rows[$];
		stim_row_t         s;
		int                phase;
		int                transfers;
		int                sends;
		int                n;
		logic [CFG_W-1:0]  hc;
		logic [CFG_W-1:0]  spt;
		logic [CFG_W-1:0]  hc_data;
		logic              l;
		logic [ADDR_W-1:0] a;
		logic [7:0]        c;
		logic [3:0]        hd;
		logic [5:0]        sc;

		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = REG_HEAD_COUNT;
		cfg_data       = '0;
		in_valid       = 1'b0;
		op             = OP_START;
		lba_mode       = 1'b0;
		task_address   = '0;
		sector_count   = '0;
		word_typed     = 1'b0;
		word_typed_res = '0;
		errors         = 0;
		starts_seen    = 0;
		sectors_seen   = 0;
		ignored_seen   = 0;
		cfg_writes_seen = 0;
		words_sent     = 0;
		idle_cycles    = 0;
		tx_calm        = 1'b0;
		rx_calm        = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back(typed_row(OP_SECTOR, 0, 28'h0000000, 8'd0, 0, 28'h0, 28'h0, 0));
		rows.push_back(typed_row(OP_START, 0, 28'h3001205, 8'd1, 0, 28'h0, 28'h3001205, 0));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0000000, 8'd0));
		rows.push_back(word_row(OP_SECTOR, 1, 28'hFFFFFFF, 8'hFF));
		rows.push_back(typed_row(OP_START, 1, 28'hFFFFFFF, 8'd2, 0, 28'h0, 28'hFFFFFFF, 0));
		rows.push_back(typed_row(OP_SECTOR, 0, 28'h0, 8'd0, 1, 28'hFFFFFFF, 28'h0, 0));
		rows.push_back(typed_row(OP_SECTOR, 0, 28'h0, 8'd0, 1, 28'h0, 28'h1, 1));
		rows.push_back(typed_row(OP_START, 0, 28'h0000000, 8'd0, 0, 28'h0, 28'h0, 0));
		rows.push_back(typed_row(OP_SECTOR, 0, 28'h0, 8'd0, 1, 28'hFFFFFFF, 28'h0, 0));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(typed_row(OP_START, 0, 28'hFFFFFFF, 8'd255, 0, 28'h0, 28'hFFFFFFF, 0));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(cfg_row(6'd4, 6'd5));
		rows.push_back(word_row(OP_START, 0, 28'h90001C7, 8'd3));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(cfg_row(6'd0, 6'd0));
		rows.push_back(word_row(OP_START, 0, 28'h0000102, 8'd2));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(cfg_row(6'd1, 6'd1));
		rows.push_back(word_row(OP_START, 0, 28'h5ABCD01, 8'd3));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));
		rows.push_back(word_row(OP_SECTOR, 0, 28'h0, 8'd0));

		foreach (rows[i]) begin
			s = rows[i];
			if (s.kind == ROW_CFG) begin
				drain_sequencer();
				set_geometry(s.heads, s.spt);
			end else begin
				send_word(s.op, s.lba, s.addr, s.count, s.typed, s.res);
			end
		end

		phase = 0;
		while (words_sent < WORD_TARGET) begin
			drain_sequencer();
			case (phase % 8)
				0:       begin hc = 6'd1;  spt = 6'd1;  end
				1:       begin hc = 6'd16; spt = 6'd63; end
				2:       begin hc = 6'd1;  spt = 6'd63; end
				3:       begin hc = 6'd16; spt = 6'd1;  end
				4:       begin hc = $urandom_range(0, 31); spt = $urandom_range(0, 63); end
				default: begin hc = $urandom_range(1, 16); spt = $urandom_range(1, 63); end
			endcase
			hc_data = hc;
			if ($urandom_range(0, 3) == 0)
				hc_data[5] = 1'b1;
			set_geometry(hc_data, spt);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);

			transfers = $urandom_range(1, 6);
			repeat (transfers) begin
				if ($urandom_range(0, 7) == 0) begin
					repeat ($urandom_range(1, 3))
						send_word($urandom_range(0, 1), $urandom_range(0, 1), $urandom(),
							$urandom(), 1'b0, '0);
				end
				l = $urandom_range(0, 1);
				if ($urandom_range(0, 1) == 0) begin
					a = $urandom();
				end else begin
					sc = (spt == 0) ? 6'd0 : $urandom_range(1, spt);
					hd = (hc[4:0] == 0) ? $urandom_range(0, 15) : $urandom_range(0, hc[4:0] - 1);
					a  = {hd, 16'($urandom()), 2'($urandom()), sc};
				end
				case ($urandom_range(0, 19))
					0:       c = 8'd0;
					1:       c = 8'd255;
					2:       c = $urandom_range(13, 254);
					default: c = $urandom_range(1, 12);
				endcase
				send_word(OP_START, l, a, c, 1'b0, '0);
				n = (c == 0) ? 256 : c;
				case ($urandom_range(0, 9))
					0:       sends = n - $urandom_range(1, n);
					1:       sends = n + $urandom_range(1, 2);
					default: sends = n;
				endcase
				repeat (sends)
					send_word(OP_SECTOR, $urandom_range(0, 1), $urandom(), $urandom(), 1'b0, '0);
			end
			phase++;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d words: %0d starts, %0d sector addresses, %0d ignored sector words.",
			words_sent, starts_seen, sectors_seen, ignored_seen);
		$display("Geometry register writes: %0d over %0d random phases; mismatches: %0d.",
			cfg_writes_seen, phase, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dsas_pkg.sv
hw/rtl/dsas_ctrl.sv
hw/rtl/dsas_datapath.sv
hw/rtl/disk_sector_address_sequencer.sv
hw/rtl/dsas_checker.sv
tb/disk_sector_address_sequencer_tb.sv
